FILE: rtl/core/pef_pkg.sv
// Shared types and constants for the polygon edge fill block.
// No dependencies.
`timescale 1ns / 1ps
package pef_pkg;

  localparam int COORD_W     = 10;
  localparam int FRAC_BITS   = 16;
  localparam int XFIX_W      = 28;
  localparam int DVD_W       = COORD_W + FRAC_BITS;
  localparam int RB_W        = 11;
  localparam int COLOR_W     = 24;
  localparam int WORD_W      = 32;
  localparam int WORD_BITS   = $clog2(WORD_W);
  localparam int FRAME_COLS  = 1 << COORD_W;
  localparam int FRAME_ROWS  = 1 << COORD_W;
  localparam int ROW_WORDS   = FRAME_COLS / WORD_W;
  localparam int WSEL_W      = $clog2(ROW_WORDS);
  localparam int MEM_DEPTH   = FRAME_ROWS * ROW_WORDS;
  localparam int MEM_AW      = $clog2(MEM_DEPTH);
  localparam int DIV_CNT_W   = $clog2(DVD_W);
  localparam int FIRST_W     = XFIX_W - FRAC_BITS;

  localparam logic [COLOR_W-1:0] WHITE_RGB = {COLOR_W{1'b1}};

  localparam logic REG_RIGHT_BOUND = 1'b0;
  localparam logic REG_FILL_COLOR  = 1'b1;

  localparam logic ACT_EDGE = 1'b0;
  localparam logic ACT_READ = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_SLOPE,
    ST_ROW,
    ST_SPAN,
    ST_RD_ISSUE,
    ST_RD_WAIT,
    ST_FINISH
  } state_t;

endpackage

FILE: rtl/core/polygon_edge_fill.sv
// Polygon edge fill top level: edge walker, slope divider and frame store control.
// Depends on pef_pkg and pef_ram.
`timescale 1ns / 1ps
// After reset the block sweeps the 1024x1024 one-bit frame store to background,
// one 32-pixel word per cycle, and takes no request until done.
// An edge request that is not horizontal runs the slope divider and loads the
// slope, then for each scanline sets up the span and toggles its 32-pixel words
// in a single read-modify-write pass over the store, word by word; a closing
// scanline check ends the edge. A horizontal edge finishes without any toggling.
// One request is handled at a time; a finished result waits in the output
// register while the next request is taken.
module polygon_edge_fill
  import pef_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      action,
  input  logic signed [COORD_W-1:0] start_x,
  input  logic signed [COORD_W-1:0] start_y,
  input  logic signed [COORD_W-1:0] end_x,
  input  logic signed [COORD_W-1:0] end_y,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      was_read,
  output logic [COLOR_W-1:0]        pixel_color,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [COLOR_W-1:0]        cfg_data
);

  state_t state, state_next;

  logic signed [RB_W-1:0]   right_bound;
  logic [COLOR_W-1:0]       fill_color;

  logic signed [COORD_W-1:0] x0, y0;
  logic signed [COORD_W-1:0] scan_row, row_end;
  logic signed [XFIX_W-1:0]  edge_x, inverse_slope;
  logic [COORD_W-1:0]        div_dvs;
  logic [COORD_W-1:0]        div_rem;
  logic [DVD_W-1:0]          div_quo;
  logic [DIV_CNT_W-1:0]      div_cnt;
  logic                      div_neg;

  logic [COORD_W-1:0]        span_first, span_last;
  logic [WSEL_W-1:0]         span_word;

  logic                      wr_pend;
  logic [MEM_AW-1:0]         wr_addr;
  logic [WORD_W-1:0]         wr_mask;
  logic [MEM_AW-1:0]         clr_cnt;
  logic [WORD_BITS-1:0]      rd_bit;

  logic                      res_read;
  logic [COLOR_W-1:0]        res_color;

  logic                      mem_we;
  logic [MEM_AW-1:0]         mem_waddr, mem_raddr;
  logic [WORD_W-1:0]         mem_wdata, mem_rdata;

  logic                      in_fire, out_free;

  // edge setup
  logic signed [COORD_W:0]   dx, dy;
  logic [COORD_W-1:0]        dx_mag, dy_mag;

  // division step
  logic [COORD_W:0]          rem_sh;
  logic                      rem_ge;

  // span bounds of the current scanline
  logic signed [XFIX_W-1:0]  x_round;
  logic signed [FIRST_W-1:0] first_col, cfirst_s, stop_s, cend_s;
  logic signed [RB_W:0]      rb_ext;
  logic                      span_ok;
  logic [COORD_W-1:0]        cfirst, clast;

  // span word mask
  logic [WORD_W-1:0]         mask_lo, mask_hi;
  logic [COORD_W-1:0]        row_addr;

  assign in_fire  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != ST_IDLE);

  assign dx     = COORD_W'(0) + ($signed({end_x[COORD_W-1], end_x})
                  - $signed({start_x[COORD_W-1], start_x}));
  assign dy     = $signed({end_y[COORD_W-1], end_y}) - $signed({start_y[COORD_W-1], start_y});
  assign dx_mag = dx[COORD_W] ? COORD_W'(-dx) : dx[COORD_W-1:0];
  assign dy_mag = dy[COORD_W] ? COORD_W'(-dy) : dy[COORD_W-1:0];

  assign rem_sh = {div_rem, div_quo[DVD_W-1]};
  assign rem_ge = (rem_sh >= {1'b0, div_dvs});

  assign x_round   = edge_x + XFIX_W'(1 << (FRAC_BITS - 1));
  assign first_col = x_round[XFIX_W-1:FRAC_BITS];
  assign cfirst_s  = (first_col < -FIRST_W'(FRAME_COLS / 2)) ? FIRST_W'(0)
                     : first_col + FIRST_W'(FRAME_COLS / 2);
  assign rb_ext    = {right_bound[RB_W-1], right_bound};
  assign stop_s    = (rb_ext > (RB_W + 1)'(FRAME_COLS / 2)) ? FIRST_W'(FRAME_COLS / 2)
                     : FIRST_W'(rb_ext);
  assign cend_s    = stop_s + FIRST_W'(FRAME_COLS / 2);
  assign span_ok   = (cfirst_s < cend_s);
  assign cfirst    = cfirst_s[COORD_W-1:0];
  assign clast     = COORD_W'(cend_s - FIRST_W'(1));

  assign mask_lo = (span_word == span_first[COORD_W-1:WORD_BITS])
                   ? ({WORD_W{1'b1}} << span_first[WORD_BITS-1:0]) : {WORD_W{1'b1}};
  assign mask_hi = (span_word == span_last[COORD_W-1:WORD_BITS])
                   ? ({WORD_W{1'b1}} >> (WORD_BITS'(WORD_W - 1) - span_last[WORD_BITS-1:0]))
                   : {WORD_W{1'b1}};
  assign row_addr = scan_row ^ COORD_W'(FRAME_ROWS / 2);

  always_comb begin
    mem_raddr = {row_addr, span_word};
    if (state == ST_RD_ISSUE) begin
      mem_raddr = {y0 ^ COORD_W'(FRAME_ROWS / 2), x0[COORD_W-1:WORD_BITS] ^ WSEL_W'(ROW_WORDS / 2)};
    end
    if (state == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt;
      mem_wdata = '0;
    end else begin
      mem_we    = wr_pend;
      mem_waddr = wr_addr;
      mem_wdata = mem_rdata ^ wr_mask;
    end
  end

  pef_ram #(.WIDTH(WORD_W), .DEPTH(MEM_DEPTH)) u_frame (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:    if (clr_cnt == MEM_AW'(MEM_DEPTH - 1)) state_next = ST_IDLE;
      ST_IDLE: begin
        if (in_fire) begin
          if (action == ACT_READ) begin
            state_next = ST_RD_ISSUE;
          end else if (dy == '0) begin
            state_next = ST_FINISH;
          end else begin
            state_next = ST_DIV;
          end
        end
      end
      ST_DIV:      if (div_cnt == '0) state_next = ST_SLOPE;
      ST_SLOPE:    state_next = ST_ROW;
      ST_ROW: begin
        if (scan_row == row_end) begin
          state_next = ST_FINISH;
        end else if (span_ok) begin
          state_next = ST_SPAN;
        end
      end
      ST_SPAN:     if (span_word == span_last[COORD_W-1:WORD_BITS]) state_next = ST_ROW;
      ST_RD_ISSUE: state_next = ST_RD_WAIT;
      ST_RD_WAIT:  state_next = ST_FINISH;
      ST_FINISH:   if (out_free) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      right_bound <= RB_W'(FRAME_COLS / 2);
      fill_color  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RIGHT_BOUND: right_bound <= cfg_data[RB_W-1:0];
        REG_FILL_COLOR:  fill_color  <= cfg_data;
        default:         fill_color  <= fill_color;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt   <= '0;
      wr_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + MEM_AW'(1);
      end
      wr_pend <= (state == ST_SPAN);
      if (state == ST_FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    wr_addr <= {row_addr, span_word};
    wr_mask <= mask_lo & mask_hi;
    unique case (state)
      ST_IDLE: begin
        x0 <= start_x;
        y0 <= start_y;
        res_read  <= (action == ACT_READ);
        res_color <= '0;
        div_dvs   <= dy_mag;
        div_rem   <= '0;
        div_quo   <= {dx_mag, FRAC_BITS'(0)};
        div_cnt   <= DIV_CNT_W'(DVD_W - 1);
        div_neg   <= dx[COORD_W] ^ dy[COORD_W];
        // walk up from the lower endpoint
        if (dy[COORD_W]) begin
          scan_row <= end_y;
          row_end  <= start_y;
          edge_x   <= {{(XFIX_W - COORD_W - FRAC_BITS){end_x[COORD_W-1]}}, end_x,
                       FRAC_BITS'(0)};
        end else begin
          scan_row <= start_y;
          row_end  <= end_y;
          edge_x   <= {{(XFIX_W - COORD_W - FRAC_BITS){start_x[COORD_W-1]}}, start_x,
                       FRAC_BITS'(0)};
        end
      end
      ST_DIV: begin
        div_rem <= rem_ge ? COORD_W'(rem_sh - {1'b0, div_dvs}) : rem_sh[COORD_W-1:0];
        div_quo <= {div_quo[DVD_W-2:0], rem_ge};
        div_cnt <= div_cnt - DIV_CNT_W'(1);
      end
      ST_SLOPE: begin
        inverse_slope <= div_neg ? -XFIX_W'(div_quo) : XFIX_W'(div_quo);
      end
      ST_ROW: begin
        span_first <= cfirst;
        span_last  <= clast;
        span_word  <= cfirst[COORD_W-1:WORD_BITS];
        if (scan_row != row_end && !span_ok) begin
          edge_x   <= edge_x + inverse_slope;
          scan_row <= scan_row + COORD_W'(1);
        end
      end
      ST_SPAN: begin
        span_word <= span_word + WSEL_W'(1);
        // advance to the next scanline after the last word
        if (span_word == span_last[COORD_W-1:WORD_BITS]) begin
          edge_x   <= edge_x + inverse_slope;
          scan_row <= scan_row + COORD_W'(1);
        end
      end
      ST_RD_ISSUE: begin
        rd_bit <= x0[WORD_BITS-1:0];
      end
      ST_RD_WAIT: begin
        res_color <= mem_rdata[rd_bit] ? fill_color : WHITE_RGB;
      end
      ST_FINISH: begin
        if (out_free) begin
          was_read    <= res_read;
          pixel_color <= res_color;
        end
      end
      default: begin
        rd_bit <= rd_bit;
      end
    endcase
  end

  // A read of the store must never race a pending toggle write.
  a_no_write_on_read: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RD_ISSUE) |-> !wr_pend)
    else $error("pixel read issued with a toggle write still pending");

  a_write_from_span: assert property (@(posedge clk) disable iff (rst)
    wr_pend |-> $past(state == ST_SPAN))
    else $error("toggle write not preceded by a span read");

  a_span_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SPAN) |-> (span_word <= span_last[COORD_W-1:WORD_BITS]))
    else $error("span word beyond last word of scanline");

  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> (!out_valid && !wr_pend))
    else $error("activity during frame store clear");

endmodule

FILE: rtl/core/pef_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
module pef_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: dv/tb_polygon_edge_fill.sv
// Self-checking testbench for polygon_edge_fill: edge fills and pixel reads
// checked against a behavioral frame-store predictor. Depends on pef_pkg and polygon_edge_fill.
`timescale 1ns / 1ps
module tb_polygon_edge_fill;
  import pef_pkg::*;

  typedef struct {
    logic                      act;
    logic signed [COORD_W-1:0] sx;
    logic signed [COORD_W-1:0] sy;
    logic signed [COORD_W-1:0] ex;
    logic signed [COORD_W-1:0] ey;
    logic                      known;
    logic [COLOR_W-1:0]        color;
  } request_t;

  typedef struct {
    logic               rd;
    logic [COLOR_W-1:0] color;
  } answer_t;

  localparam int IDLE_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic action = ACT_EDGE;
  logic signed [COORD_W-1:0] start_x = '0, start_y = '0, end_x = '0, end_y = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  logic was_read;
  logic [COLOR_W-1:0] pixel_color;
  logic cfg_we = 1'b0;
  logic cfg_index = REG_RIGHT_BOUND;
  logic [COLOR_W-1:0] cfg_data = '0;

  polygon_edge_fill dut (.*);

  initial begin
    forever #10 clk = ~clk;
  end

  // predictor state
  bit                        mask_model [FRAME_ROWS][FRAME_COLS];
  logic signed [RB_W-1:0]    bound_model = 11'sd512;
  logic [COLOR_W-1:0]        color_model = '0;
  answer_t                   pending_answers[$];
  int                        fails = 0;
  int                        idle_cycles = 0;
  bit                        hold_off = 1'b0;

  function automatic longint floor_q(longint a);
    longint q;
    q = a / 65536;
    if ((a % 65536) != 0 && a < 0) q--;
    return q;
  endfunction

  function automatic void fill_edge(longint x0, longint y0, longint x1, longint y1);
    longint dy, slope, xf, ylo, yhi, row, first, stop, col;
    dy = y1 - y0;
    if (dy == 0) return;
    slope = ((x1 - x0) * 65536) / dy;
    if (y0 < y1) begin
      ylo = y0; yhi = y1; xf = x0 * 65536;
    end else begin
      ylo = y1; yhi = y0; xf = x1 * 65536;
    end
    for (row = ylo; row < yhi; row++) begin
      first = floor_q(xf + 32768);
      if (first < -512) first = -512;
      stop = bound_model < 512 ? longint'(bound_model) : 512;
      for (col = first; col < stop; col++)
        mask_model[row + 512][col + 512] ^= 1'b1;
      xf += slope;
    end
  endfunction

  function automatic answer_t predict_answer(request_t r);
    answer_t a;
    if (r.act == ACT_READ) begin
      a.rd = 1'b1;
      a.color = mask_model[int'(r.sy) + 512][int'(r.sx) + 512] ? color_model : WHITE_RGB;
    end else begin
      a.rd = 1'b0;
      a.color = '0;
      fill_edge(r.sx, r.sy, r.ex, r.ey);
    end
    if (r.known && a.color !== r.color) begin
      $error("typed color: expected %h, predicted %h", r.color, a.color);
      fails++;
    end
    return a;
  endfunction

  task automatic write_reg(logic idx, logic [COLOR_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_RIGHT_BOUND) bound_model = val[RB_W-1:0];
    else color_model = val;
    @(posedge clk);
  endtask

  // valid stays up across back-to-back requests; drop it only for a gap
  task automatic send_request(request_t r);
    int gap;
    gap = $urandom_range(0, 15);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= r.act;
    start_x <= r.sx;
    start_y <= r.sy;
    end_x <= r.ex;
    end_y <= r.ey;
    do @(posedge clk); while (in_stall);
    pending_answers.push_back(predict_answer(r));
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic request_t rd_req(int x, int y, logic k = 1'b0,
                                      logic [COLOR_W-1:0] c = '0);
    request_t r;
    r.act = ACT_READ; r.sx = COORD_W'(x); r.sy = COORD_W'(y);
    r.ex = COORD_W'($urandom); r.ey = COORD_W'($urandom); r.known = k; r.color = c;
    return r;
  endfunction

  function automatic request_t edge_req(int x0, int y0, int x1, int y1);
    request_t r;
    r.act = ACT_EDGE; r.sx = COORD_W'(x0); r.sy = COORD_W'(y0);
    r.ex = COORD_W'(x1); r.ey = COORD_W'(y1);
    r.known = 1'b1; r.color = '0;
    return r;
  endfunction

  // random edge, mostly short so the run stays fast; now and then fully random
  function automatic request_t rand_edge();
    int x0, y0;
    x0 = $urandom_range(0, 1023) - 512;
    y0 = $urandom_range(0, 1023) - 512;
    if ($urandom_range(0, 19) == 0)
      return edge_req(x0, y0, int'($urandom_range(0, 1023)) - 512,
                      int'($urandom_range(0, 1023)) - 512);
    return edge_req(x0, y0, x0 + int'($urandom_range(0, 40)) - 20,
                    y0 + int'($urandom_range(0, 12)) - 6);
  endfunction

  // result side
  initial begin
    int wait_n;
    answer_t exp_a;
    @(negedge rst);
    forever begin
      wait_n = $urandom_range(0, 15);
      if ($urandom_range(0, 3) == 0) wait_n = 0;
      if (hold_off) begin
        out_stall <= 1'b1;
        while (hold_off) @(posedge clk);
      end else if (wait_n != 0) begin
        out_stall <= 1'b1;
        repeat (wait_n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      if (pending_answers.size() == 0) begin
        $error("unexpected result: was_read=%b pixel_color=%h", was_read, pixel_color);
        fails++;
      end else begin
        exp_a = pending_answers.pop_front();
        if (was_read !== exp_a.rd) begin
          $error("was_read: expected %b, actual %b", exp_a.rd, was_read);
          fails++;
        end
        if (pixel_color !== exp_a.color) begin
          $error("pixel_color: expected %h, actual %h", exp_a.color, pixel_color);
          fails++;
        end
      end
    end
  end

  // watchdog on accepted requests and results
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("** polygon_edge_fill: FAILED **");
      $finish;
    end
  end

  request_t directed_rows[] = '{
    rd_req(0, 0, 1, WHITE_RGB),
    rd_req(-512, -512, 1, WHITE_RGB),
    rd_req(511, 511, 1, WHITE_RGB),
    edge_req(10, 5, 200, 5),                  // horizontal edge
    edge_req(0, 0, 0, 4),
    rd_req(0, 0), rd_req(-1, 0), rd_req(511, 3), rd_req(0, 4),
    edge_req(-512, -512, 511, -509),
    rd_req(-512, -512), rd_req(511, -510),
    edge_req(511, 511, -512, 508),            // end point below start
    rd_req(100, 509), rd_req(511, 510),
    edge_req(5, -20, -7, -13),
    rd_req(-3, -17), rd_req(300, -15),
    edge_req(0, 0, 0, 4),                     // toggle back
    rd_req(0, 0, 1, WHITE_RGB)
  };

  initial begin
    int i, n;
    request_t r;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    write_reg(REG_FILL_COLOR, 24'h123456);
    foreach (directed_rows[k]) send_request(directed_rows[k]);
    drain();

    // long hold-off on results while requests keep coming
    hold_off = 1'b1;
    fork
      begin
        repeat (3000) @(posedge clk);
        hold_off = 1'b0;
      end
      for (i = 0; i < 12; i++) send_request(rd_req(int'($urandom_range(0, 1023)) - 512, 0));
    join
    drain();

    for (n = 0; n < 6; n++) begin
      case (n)
        0: write_reg(REG_RIGHT_BOUND, 24'(-11'sd512));
        1: write_reg(REG_RIGHT_BOUND, 24'(11'sd512));
        2: write_reg(REG_FILL_COLOR, WHITE_RGB);
        3: write_reg(REG_FILL_COLOR, 24'h000000);
        default: begin
          write_reg(REG_RIGHT_BOUND, 24'($urandom_range(0, 1024)) - 24'd512);
          write_reg(REG_FILL_COLOR, 24'($urandom));
        end
      endcase
      for (i = 0; i < 68; i++) begin
        if ($urandom_range(0, 2) == 0) begin
          r = rand_edge();
          send_request(r);
          send_request(rd_req(r.sx, r.sy));
        end else begin
          send_request(rd_req(int'($urandom_range(0, 1023)) - 512,
                              int'($urandom_range(0, 1023)) - 512));
        end
      end
      drain();
    end

    if (fails == 0) $display("** polygon_edge_fill: PASSED **");
    else $display("** polygon_edge_fill: FAILED **");
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/pef_pkg.sv
rtl/core/pef_ram.sv
rtl/core/polygon_edge_fill.sv
dv/tb_polygon_edge_fill.sv
